@@ hdl/pad_pkg.sv @@
// shared types, widths and register codes of the polyline area decimator
package pad_pkg;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned THR_BITS   = 51;
  localparam int unsigned STEP_BITS  = 8;

  // shoelace arithmetic widths
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned AREA_W = (PROD_W + 1 > THR_BITS) ? PROD_W + 1 : THR_BITS;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;

  // kept point queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // segment list filled by one decision
  localparam int unsigned MAX_SEGS  = 4;
  localparam int unsigned SEG_IDX_W = $clog2(MAX_SEGS);
  localparam int unsigned SEG_CNT_W = $clog2(MAX_SEGS + 1);

  // configuration port
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_STEP    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REDUCE_ENABLE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_AREA_THRESHOLD = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    point_t pt;
    logic   fin;
  } kept_t;

  typedef struct packed {
    point_t pos;
    point_t nb;
    logic   done;
  } seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hdl/pad_front.sv @@
// front end: raw point intake and subsampling
module pad_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pad_pkg::point_t                in_point_i,
  input  logic                           in_fin_i,
  input  logic [pad_pkg::STEP_BITS-1:0]  sample_step_i,
  input  pad_pkg::q_status_t             q_status_i,
  output logic                           push_o,
  output pad_pkg::kept_t                 push_data_o
);
  import pad_pkg::*;

  logic [STEP_BITS-1:0] phase_q, phase_d;
  logic [STEP_BITS-1:0] step_eff;
  logic [STEP_BITS-1:0] phase_inc;
  logic                 accept;
  logic                 kept;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign kept       = in_fin_i || (phase_q == '0);

  // zero step behaves as one
  assign step_eff  = (sample_step_i == '0) ? STEP_BITS'(1) : sample_step_i;
  assign phase_inc = phase_q + STEP_BITS'(1);

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (in_fin_i) begin
        phase_d = '0;
      end else if (phase_inc >= step_eff || phase_inc == '0) begin
        phase_d = '0;
      end else begin
        phase_d = phase_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign push_o          = accept && kept;
  assign push_data_o.pt  = in_point_i;
  assign push_data_o.fin = in_fin_i;

endmodule

@@ hdl/pad_queue.sv @@
// short queue of kept points between front and back end
module pad_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pad_pkg::kept_t     push_data_i,
  input  logic               pop_i,
  output pad_pkg::kept_t     head_o,
  output pad_pkg::q_status_t status_o
);
  import pad_pkg::*;

  kept_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QUEUE_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QUEUE_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hdl/pad_back.sv @@
// back end: shoelace test, run bookkeeping and segment drain
module pad_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          reduce_enable_i,
  input  logic [pad_pkg::THR_BITS-1:0]  area_threshold_i,
  input  pad_pkg::kept_t                head_i,
  input  pad_pkg::q_status_t            q_status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pad_pkg::seg_t                 out_seg_o
);
  import pad_pkg::*;

  // line history
  logic [1:0] ks_q, ks_d;
  point_t     anchor_q, anchor_d;
  point_t     older_q, older_d;
  point_t     newer_q, newer_d;
  logic       aio_q, aio_d;

  // popped point and registered products
  point_t                    c_q;
  logic                      fin_q;
  logic signed [PROD_W-1:0]  prod1_q, prod2_q;
  logic                      dec_q;

  // segment list and drain
  seg_t                 seg_q [MAX_SEGS];
  seg_t                 seg_d [MAX_SEGS];
  logic [SEG_CNT_W-1:0] rem_q, rem_d;
  logic [SEG_IDX_W-1:0] idx_q;
  logic [SEG_CNT_W-1:0] n_seg;
  logic                 load;
  logic                 out_valid_q;
  seg_t                 out_q;

  logic signed [DIFF_W-1:0] d_ac_x, d_ba_y, d_ab_x, d_ca_y;
  logic signed [PROD_W-1:0] prod1, prod2;
  logic signed [AREA_W-1:0] area;
  logic signed [AREA_W-1:0] thr;
  logic                     below;

  assign pop_o = !q_status_i.empty && !dec_q && (rem_q == '0);

  // a = older, b = newer, c = queue head
  assign d_ac_x = DIFF_W'(older_q.x) - DIFF_W'(head_i.pt.x);
  assign d_ba_y = DIFF_W'(newer_q.y) - DIFF_W'(older_q.y);
  assign d_ab_x = DIFF_W'(older_q.x) - DIFF_W'(newer_q.x);
  assign d_ca_y = DIFF_W'(head_i.pt.y) - DIFF_W'(older_q.y);
  assign prod1  = d_ac_x * d_ba_y;
  assign prod2  = d_ab_x * d_ca_y;

  assign area  = AREA_W'(prod1_q) - AREA_W'(prod2_q);
  assign thr   = AREA_W'($signed(area_threshold_i));
  assign below = (area < thr);

  always_comb begin
    ks_d     = ks_q;
    anchor_d = anchor_q;
    older_d  = older_q;
    newer_d  = newer_q;
    aio_d    = aio_q;
    n_seg    = '0;
    for (int i = 0; i < MAX_SEGS; i++) begin
      seg_d[i] = seg_q[i];
    end
    if (dec_q) begin
      if (reduce_enable_i) begin
        unique case (ks_q)
          2'd0: begin
            older_d  = c_q;
            newer_d  = c_q;
            anchor_d = c_q;
            aio_d    = 1'b1;
            ks_d     = 2'd1;
          end
          2'd1: begin
            newer_d = c_q;
            ks_d    = 2'd2;
          end
          default: begin
            if (below) begin
              older_d = newer_q;
              newer_d = c_q;
              aio_d   = 1'b0;
            end else begin
              if (!aio_q) begin
                seg_d[n_seg[SEG_IDX_W-1:0]] = '{pos: anchor_q, nb: older_q, done: 1'b0};
                n_seg = n_seg + SEG_CNT_W'(1);
              end
              seg_d[n_seg[SEG_IDX_W-1:0]] = '{pos: older_q, nb: newer_q, done: 1'b0};
              n_seg    = n_seg + SEG_CNT_W'(1);
              anchor_d = newer_q;
              older_d  = newer_q;
              newer_d  = c_q;
              aio_d    = 1'b1;
            end
          end
        endcase
        if (fin_q) begin
          if (!aio_d) begin
            seg_d[n_seg[SEG_IDX_W-1:0]] = '{pos: anchor_d, nb: older_d, done: 1'b0};
            n_seg = n_seg + SEG_CNT_W'(1);
            seg_d[n_seg[SEG_IDX_W-1:0]] = '{pos: older_d, nb: newer_d, done: 1'b1};
            n_seg = n_seg + SEG_CNT_W'(1);
          end else begin
            seg_d[n_seg[SEG_IDX_W-1:0]] = '{pos: older_d, nb: newer_d, done: 1'b0};
            n_seg = n_seg + SEG_CNT_W'(1);
            seg_d[n_seg[SEG_IDX_W-1:0]] = '{pos: newer_d, nb: newer_d, done: 1'b1};
            n_seg = n_seg + SEG_CNT_W'(1);
          end
        end
      end else begin
        if (ks_q == 2'd0) begin
          older_d = c_q;
          newer_d = c_q;
          ks_d    = 2'd1;
        end else begin
          older_d = (ks_q == 2'd1) ? older_q : newer_q;
          seg_d[n_seg[SEG_IDX_W-1:0]] = '{pos: older_d, nb: c_q, done: 1'b0};
          n_seg   = n_seg + SEG_CNT_W'(1);
          newer_d = c_q;
          ks_d    = 2'd2;
        end
        anchor_d = older_d;
        aio_d    = 1'b1;
        if (fin_q) begin
          seg_d[n_seg[SEG_IDX_W-1:0]] = '{pos: c_q, nb: c_q, done: 1'b1};
          n_seg = n_seg + SEG_CNT_W'(1);
        end
      end
      if (fin_q) begin
        ks_d  = 2'd0;
        aio_d = 1'b1;
      end
    end
  end

  assign load = (rem_q != '0) && (!out_valid_q || out_ready_i);

  always_comb begin
    rem_d = rem_q;
    if (dec_q) begin
      rem_d = n_seg;
    end else if (load) begin
      rem_d = rem_q - SEG_CNT_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      c_q     <= head_i.pt;
      fin_q   <= head_i.fin;
      prod1_q <= prod1;
      prod2_q <= prod2;
    end
    if (dec_q) begin
      for (int i = 0; i < MAX_SEGS; i++) begin
        seg_q[i] <= seg_d[i];
      end
    end
    if (load) begin
      out_q <= seg_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q        <= 2'd0;
      anchor_q    <= '0;
      older_q     <= '0;
      newer_q     <= '0;
      aio_q       <= 1'b1;
      dec_q       <= 1'b0;
      rem_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ks_q     <= ks_d;
      anchor_q <= anchor_d;
      older_q  <= older_d;
      newer_q  <= newer_d;
      aio_q    <= aio_d;
      dec_q    <= pop_o;
      rem_q    <= rem_d;
      if (dec_q) begin
        idx_q <= '0;
      end else if (load) begin
        idx_q <= idx_q + SEG_IDX_W'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_seg_o   = out_q;

endmodule

@@ hdl/polyline_area_decimator_core.sv @@
// top level of the polyline area decimator: config registers, front, queue, back
// path: kept point -> queue -> product registers -> segment list -> output register
// throughput: raw points one per cycle while the four-entry queue has room; the back end
//   pops a kept point only once every segment (at most four) of the previous one has left the list
// reset: asynchronous active low; clears the line history, queue and output valid,
//   and sets sample_step to 1, reduce_enable to 1 and area_threshold to 0
module polyline_area_decimator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // raw points
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pad_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // point_x, point_y
  input  logic                            s_axis_tlast,  // final_point
  // segments
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pad_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // pos_x, pos_y, neighbour_x, neighbour_y
  output logic                            m_axis_tlast,  // line_done
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pad_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pad_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pad_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pad_pkg::*;

  logic [STEP_BITS-1:0] sample_step_q;
  logic                 reduce_enable_q;
  logic [THR_BITS-1:0]  area_threshold_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  point_t    in_point;
  logic      push;
  kept_t     push_data;
  logic      pop;
  kept_t     head;
  q_status_t q_status;
  seg_t      out_seg;

  // registers sit at 8-byte steps, the high address bits pick one
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_step_q    <= STEP_BITS'(1);
      reduce_enable_q  <= 1'b1;
      area_threshold_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SAMPLE_STEP:    sample_step_q    <= pwdata[STEP_BITS-1:0];
        REG_REDUCE_ENABLE:  reduce_enable_q  <= pwdata[0];
        REG_AREA_THRESHOLD: area_threshold_q <= pwdata[THR_BITS-1:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SAMPLE_STEP:    prdata = APB_DATA_W'(sample_step_q);
      REG_REDUCE_ENABLE:  prdata = APB_DATA_W'(reduce_enable_q);
      REG_AREA_THRESHOLD: prdata = APB_DATA_W'(area_threshold_q);
      default:            prdata = '0;
    endcase
  end

  // unpack the raw point, x in the low bits
  assign in_point.x = s_axis_tdata[COORD_BITS-1:0];
  assign in_point.y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

  // sampling runs at line rate while the queue has room; only kept points enter the queue
  pad_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_point_i    (in_point),
    .in_fin_i      (s_axis_tlast),
    .sample_step_i (sample_step_q),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  pad_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // back end: products on pop, decision in the cycle after, then drain the segment list
  pad_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .reduce_enable_i  (reduce_enable_q),
    .area_threshold_i (area_threshold_q),
    .head_i           (head),
    .q_status_i       (q_status),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_seg_o        (out_seg)
  );

  // pack the segment, pos_x in the low bits
  assign m_axis_tdata = OUT_DATA_W'({out_seg.nb.y, out_seg.nb.x, out_seg.pos.y, out_seg.pos.x});
  assign m_axis_tlast = out_seg.done;

endmodule

@@ hdl/pad_checker.sv @@
// port level checks of the polyline area decimator, bound to the top level
module pad_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pad_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [pad_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [pad_pkg::APB_DATA_W-1:0]  pwdata,
  input logic [pad_pkg::APB_DATA_W-1:0]  prdata
);
  import pad_pkg::*;

  // a stalled segment stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("segment withdrawn while stalled");

  // a stalled segment keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("segment payload changed while stalled");

  // sample step reads back the low bits written, upper bits zero
  a_step_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[APB_ADDR_W-1:3] == REG_SAMPLE_STEP)
      ##1 (paddr[APB_ADDR_W-1:3] == REG_SAMPLE_STEP)
    |-> prdata == APB_DATA_W'($past(pwdata[STEP_BITS-1:0])))
    else $error("sample step readback mismatch");

  // threshold reads back the low bits written, upper bits zero
  a_thr_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[APB_ADDR_W-1:3] == REG_AREA_THRESHOLD)
      ##1 (paddr[APB_ADDR_W-1:3] == REG_AREA_THRESHOLD)
    |-> prdata == APB_DATA_W'($past(pwdata[THR_BITS-1:0])))
    else $error("area threshold readback mismatch");

endmodule

bind polyline_area_decimator_core pad_checker u_pad_checker (.*);
